// File: sv/perspective_project_point_unit_defines.svh
// Assertion macros shared by the projection unit RTL.
// No dependencies; included by files that carry assertions.
`ifndef PERSPECTIVE_PROJECT_POINT_UNIT_DEFINES_SVH
`define PERSPECTIVE_PROJECT_POINT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check held outside reset
`define PPP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check held at every edge, reset included
`define PPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PPP_ASSERT(lbl, clk, rst, prop, msg)
`define PPP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/ppp_pkg.sv
// Types and constants of the perspective projection unit.
// No dependencies.
package ppp_pkg;
   localparam int COORD_W = 32;
   localparam int PIX_W   = 12;
   localparam int IDX_W   = 3;

   localparam logic [IDX_W-1:0] REG_CAM_X       = 3'd0;
   localparam logic [IDX_W-1:0] REG_CAM_Y       = 3'd1;
   localparam logic [IDX_W-1:0] REG_CAM_Z       = 3'd2;
   localparam logic [IDX_W-1:0] REG_FOCAL       = 3'd3;
   localparam logic [IDX_W-1:0] REG_HALF_WIDTH  = 3'd4;
   localparam logic [IDX_W-1:0] REG_HALF_HEIGHT = 3'd5;

   localparam logic [31:0]      FOCAL_RESET     = 32'd33969144;
   localparam logic [PIX_W-1:0] HALF_W_RESET    = 12'd320;
   localparam logic [PIX_W-1:0] HALF_H_RESET    = 12'd240;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cam_x;
      logic signed [COORD_W-1:0] cam_y;
      logic signed [COORD_W-1:0] cam_z;
      logic        [COORD_W-1:0] focal_length;
      logic        [PIX_W-1:0]   half_width;
      logic        [PIX_W-1:0]   half_height;
   } cfg_type;
endpackage

// File: sv/perspective_project_point_unit.sv
// Top level of the pinhole perspective projection unit.
// Depends on ppp_pkg, ppp_front, ppp_div_step and the defines header.
//
// Usage:
//  - req_ channel carries one point (x, y, z, signed Q16.16) per transaction.
//  - rsp_ channel returns screen_x/screen_y (signed Q16.16, saturated),
//    one transaction per request, in request order.
//  - csr_ channel writes camera x/y/z, focal length, half width, half height
//    by register index 0..5; higher indexes are ignored. csr_ready is always
//    high. Write only while no transaction is in flight.
//  - Depth: 4 front stages + QB divider steps + 1 output stage, where
//    QB = max(33, FRAC_BITS+13) + 1.
//  - Throughput: one transaction per cycle unless stalled; each quotient bit
//    has its own pipeline step, so the divider chain sets the depth, not the rate.
//  - Reset empties the pipeline and loads the register reset values.
//  - While rsp_valid is high and rsp_ready low the whole pipeline holds and
//    req_ready is low; nothing is dropped or repeated.
`include "perspective_project_point_unit_defines.svh"
module perspective_project_point_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ppp_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output ppp_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ppp_pkg::IDX_W-1:0]   csr_index,
   input  logic [31:0]                 csr_wdata
);
   import ppp_pkg::*;

   localparam int QB = ((FRAC_BITS + 13 > 33) ? FRAC_BITS + 13 : 33) + 1;
   localparam int RW = 34;
   localparam int LW = 2 + RW + QB;
   localparam int SW = QB + 2;
   localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFFFFFF);
   localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sh80000000);

   logic adv;

   // configuration registers
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_x        <= '0;
         cfg_ff.cam_y        <= '0;
         cfg_ff.cam_z        <= '0;
         cfg_ff.focal_length <= FOCAL_RESET;
         cfg_ff.half_width   <= HALF_W_RESET;
         cfg_ff.half_height  <= HALF_H_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CAM_X:       cfg_ff.cam_x        <= csr_wdata;
            REG_CAM_Y:       cfg_ff.cam_y        <= csr_wdata;
            REG_CAM_Z:       cfg_ff.cam_z        <= csr_wdata;
            REG_FOCAL:       cfg_ff.focal_length <= csr_wdata;
            REG_HALF_WIDTH:  cfg_ff.half_width   <= csr_wdata[PIX_W-1:0];
            REG_HALF_HEIGHT: cfg_ff.half_height  <= csr_wdata[PIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // whole pipeline moves when the output slot is free or being drained
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // front stages and divider chain
   logic [QB:0]   vld_w;
   logic [32:0]   dz_w [QB+1];
   logic [LW-1:0] lx_w [QB+1];
   logic [LW-1:0] ly_w [QB+1];

   ppp_front #(.FRAC_BITS(FRAC_BITS), .QB(QB), .RW(RW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid),
      .in_data    (req_data),
      .cfg        (cfg_ff),
      .out_valid  (vld_w[0]),
      .out_dz     (dz_w[0]),
      .out_lane_x (lx_w[0]),
      .out_lane_y (ly_w[0])
   );

   for (genvar i = 0; i < QB; i++) begin : g_div
      ppp_div_step #(.QB(QB), .RW(RW)) u_step (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .in_valid   (vld_w[i]),
         .in_dz      (dz_w[i]),
         .in_lane_x  (lx_w[i]),
         .in_lane_y  (ly_w[i]),
         .out_valid  (vld_w[i+1]),
         .out_dz     (dz_w[i+1]),
         .out_lane_x (lx_w[i+1]),
         .out_lane_y (ly_w[i+1])
      );
   end

   // final stage: sign, offset and saturation
   logic [QB-1:0]        qx_w, qy_w;
   logic signed [SW-1:0] sqx_w, sqy_w, hw_w, hh_w, sx_w, sy_w;
   logic                 out_vld_ff;
   rsp_type              out_ff, out_in;

   always_comb begin
      qx_w  = lx_w[QB][LW-2] ? '1 : lx_w[QB][QB-1:0];
      qy_w  = ly_w[QB][LW-2] ? '1 : ly_w[QB][QB-1:0];
      sqx_w = lx_w[QB][LW-1] ? -SW'(qx_w) : SW'(qx_w);
      sqy_w = ly_w[QB][LW-1] ? -SW'(qy_w) : SW'(qy_w);
      hw_w  = SW'(cfg_ff.half_width) <<< FRAC_BITS;
      hh_w  = SW'(cfg_ff.half_height) <<< FRAC_BITS;
      sx_w  = hw_w + sqx_w;
      sy_w  = hh_w - sqy_w;
      priority if (sx_w > SAT_MAX) begin
         out_in.screen_x = SAT_MAX[31:0];
      end else if (sx_w < SAT_MIN) begin
         out_in.screen_x = SAT_MIN[31:0];
      end else begin
         out_in.screen_x = sx_w[31:0];
      end
      priority if (sy_w > SAT_MAX) begin
         out_in.screen_y = SAT_MAX[31:0];
      end else if (sy_w < SAT_MIN) begin
         out_in.screen_y = SAT_MIN[31:0];
      end else begin
         out_in.screen_y = sy_w[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_w[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // checks
   `PPP_ASSERT(a_stall_blocks_req, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready, "request taken during output stall")
   `PPP_ASSERT(a_stall_holds_pipe, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(vld_w), "pipeline valids moved during stall")
   `PPP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && vld_w == '0), "pipeline not empty after reset")
endmodule

// File: sv/ppp_front.sv
// Front stages: camera offset, depth clamp, focal product, divide setup.
// Depends on ppp_pkg.
module ppp_front #(
   parameter int FRAC_BITS = 16,
   parameter int QB        = 34,
   parameter int RW        = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  ppp_pkg::req_type      in_data,
   input  ppp_pkg::cfg_type      cfg,
   output logic                  out_valid,
   output logic [32:0]           out_dz,
   output logic [2+RW+QB-1:0]    out_lane_x,
   output logic [2+RW+QB-1:0]    out_lane_y
);
   import ppp_pkg::*;

   localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

   // stage 1: differences and clamped depth
   logic [3:0] vld_ff, vld_in;
   logic signed [32:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [32:0] dz1_ff, dz1_in;
   logic signed [33:0] pz_w, cz_w;

   always_comb begin
      pz_w  = 34'(in_data.point_z);
      cz_w  = 34'(cfg.cam_z);
      dx_in = 33'(in_data.point_x) - 33'(cfg.cam_x);
      dy_in = 33'(in_data.point_y) - 33'(cfg.cam_y);
      if (pz_w < cz_w + ONE) begin
         dz1_in = 33'(ONE);
      end else begin
         dz1_in = 33'(pz_w - cz_w);
      end
   end

   // stage 2: sign, magnitude and partial products
   logic nx2_ff, ny2_ff;
   logic [32:0] dz2_ff, mx_w, my_w;
   logic [47:0] plx_ff, ply_ff;
   logic [48:0] phx_ff, phy_ff;

   assign mx_w = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign my_w = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);

   // stage 3: full products
   logic nx3_ff, ny3_ff;
   logic [32:0] dz3_ff;
   logic [63:0] px3_ff, py3_ff;

   // stage 4: overflow flags and starting remainders
   logic nx4_ff, ny4_ff, ox4_ff, oy4_ff;
   logic [32:0] dz4_ff;
   logic [RW-1:0] rx4_ff, ry4_ff;
   logic [QB-1:0] qx4_ff, qy4_ff;

   assign vld_in = {vld_ff[2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz1_ff <= dz1_in;
         nx2_ff <= dx_ff[32];
         ny2_ff <= dy_ff[32];
         dz2_ff <= dz1_ff;
         plx_ff <= cfg.focal_length * mx_w[15:0];
         ply_ff <= cfg.focal_length * my_w[15:0];
         phx_ff <= cfg.focal_length * mx_w[32:16];
         phy_ff <= cfg.focal_length * my_w[32:16];
         nx3_ff <= nx2_ff;
         ny3_ff <= ny2_ff;
         dz3_ff <= dz2_ff;
         px3_ff <= 64'(plx_ff) + (64'(phx_ff) << 16);
         py3_ff <= 64'(ply_ff) + (64'(phy_ff) << 16);
         nx4_ff <= nx3_ff;
         ny4_ff <= ny3_ff;
         dz4_ff <= dz3_ff;
         ox4_ff <= 33'(px3_ff[63:QB]) >= dz3_ff;
         oy4_ff <= 33'(py3_ff[63:QB]) >= dz3_ff;
         rx4_ff <= RW'(px3_ff[63:QB]);
         ry4_ff <= RW'(py3_ff[63:QB]);
         qx4_ff <= px3_ff[QB-1:0];
         qy4_ff <= py3_ff[QB-1:0];
      end
   end

   assign out_valid  = vld_ff[3];
   assign out_dz     = dz4_ff;
   assign out_lane_x = {nx4_ff, ox4_ff, rx4_ff, qx4_ff};
   assign out_lane_y = {ny4_ff, oy4_ff, ry4_ff, qy4_ff};
endmodule

// File: sv/ppp_div_step.sv
// One restoring-division step for both lanes, registered.
// Depends on ppp_pkg.
module ppp_div_step #(
   parameter int QB = 34,
   parameter int RW = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [32:0]          in_dz,
   input  logic [2+RW+QB-1:0]   in_lane_x,
   input  logic [2+RW+QB-1:0]   in_lane_y,
   output logic                 out_valid,
   output logic [32:0]          out_dz,
   output logic [2+RW+QB-1:0]   out_lane_x,
   output logic [2+RW+QB-1:0]   out_lane_y
);
   import ppp_pkg::*;

   localparam int LW = 2 + RW + QB;

   logic          vld_ff;
   logic [32:0]   dz_ff;
   logic [LW-1:0] lx_ff, lx_in, ly_ff, ly_in;

   function automatic logic [LW-1:0] step(input logic [LW-1:0] l, input logic [32:0] d);
      logic [RW-1:0] t;
      logic [RW-1:0] r;
      logic [QB-1:0] q;
      logic          b;
      t = {l[QB+RW-2:QB], l[QB-1]};
      b = t >= RW'(d);
      r = b ? RW'(t - RW'(d)) : t;
      q = {l[QB-2:0], b};
      return {l[LW-1:LW-2], r, q};
   endfunction

   assign lx_in = step(in_lane_x, in_dz);
   assign ly_in = step(in_lane_y, in_dz);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dz_ff <= in_dz;
         lx_ff <= lx_in;
         ly_ff <= ly_in;
      end
   end

   assign out_valid  = vld_ff;
   assign out_dz     = dz_ff;
   assign out_lane_x = lx_ff;
   assign out_lane_y = ly_ff;
endmodule

// File: bench/perspective_project_point_unit_test.sv
// Testbench for the pinhole perspective projection unit.
// Depends on ppp_pkg and perspective_project_point_unit; self-checking, no files read.
`timescale 1ns / 1ps
module perspective_project_point_unit_test;
   import ppp_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 39;
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd6;
   localparam logic [IDX_W-1:0] REG_SPARE  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // predictor copy of the camera registers
   logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
   logic [31:0] focal_q;
   logic [11:0] half_w_q, half_h_q;

   rsp_type screen_queue[$];
   int mismatch_count = 0;
   int checked_count = 0;
   int sent_count = 0;
   bit sink_busy_idle = 1'b1;   // 1: receiver stalls at random
   bit src_busy_idle = 1'b1;
   int hold_cycles = 0;         // forced long receiver hold

   perspective_project_point_unit dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // mismatch reporting
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      begin
         mismatch_count++;
         $display("MISMATCH %s: got %h expected %h (transaction %0d)",
                  what, got, want, checked_count);
      end
   endtask

   // focal * num / den truncated toward zero, clamped at 2^40 magnitude
   function automatic logic signed [63:0] scaled_quotient(input logic signed [63:0] num,
                                                          input logic [63:0] den);
      logic [63:0] mag;
      logic [63:0] q;
      begin
         mag = (num < 0) ? -num : num;
         q = ({32'd0, focal_q} * mag) / den;
         if (q > (64'd1 << 40)) q = 64'd1 << 40;
         scaled_quotient = (num < 0) ? -$signed(q) : $signed(q);
      end
   endfunction

   function automatic logic [31:0] saturate32(input logic signed [63:0] v);
      begin
         if (v > 64'sd2147483647) saturate32 = 32'h7fffffff;
         else if (v < -64'sd2147483648) saturate32 = 32'h80000000;
         else saturate32 = v[31:0];
      end
   endfunction

   function automatic rsp_type project_point(input req_type p);
      logic signed [63:0] dx, dy, dz, one, hw, hh;
      rsp_type r;
      begin
         one = 64'sd1 <<< FRAC;
         dx = 64'(p.point_x) - 64'(cam_x_q);
         dy = 64'(p.point_y) - 64'(cam_y_q);
         if (64'(p.point_z) < 64'(cam_z_q) + one) dz = one;
         else dz = 64'(p.point_z) - 64'(cam_z_q);
         hw = 64'(half_w_q) <<< FRAC;
         hh = 64'(half_h_q) <<< FRAC;
         r.screen_x = saturate32(hw + scaled_quotient(dx, dz));
         r.screen_y = saturate32(hh - scaled_quotient(dy, dz));
         project_point = r;
      end
   endfunction

   // send one point and record its expected screen position;
   // valid drops only while the sender idles
   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
      req_type p;
      begin
         p.point_x = x;
         p.point_y = y;
         p.point_z = z;
         while (src_busy_idle && $urandom_range(99) < 34) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data <= p;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         screen_queue.push_back(project_point(p));
         sent_count++;
         @(negedge clock);
      end
   endtask

   // one register write; only while the pipeline is empty
   task automatic write_register(input logic [IDX_W-1:0] idx, input logic [31:0] value);
      begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx)
            REG_CAM_X: cam_x_q = value;
            REG_CAM_Y: cam_y_q = value;
            REG_CAM_Z: cam_z_q = value;
            REG_FOCAL: focal_q = value;
            REG_HALF_WIDTH: half_w_q = value[11:0];
            REG_HALF_HEIGHT: half_h_q = value[11:0];
            default: ;
         endcase
         @(negedge clock);
         csr_valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_drained;
      begin
         req_valid <= 1'b0;
         while (screen_queue.size() != 0) @(negedge clock);
         repeat (LATENCY + 4) @(negedge clock);
      end
   endtask

   task automatic write_camera(input logic [31:0] cx, input logic [31:0] cy,
                               input logic [31:0] cz, input logic [31:0] f,
                               input logic [31:0] hw, input logic [31:0] hh);
      begin
         wait_drained();
         write_register(REG_CAM_X, cx);
         write_register(REG_CAM_Y, cy);
         write_register(REG_CAM_Z, cz);
         write_register(REG_FOCAL, f);
         write_register(REG_HALF_WIDTH, hw);
         write_register(REG_HALF_HEIGHT, hh);
      end
   endtask

   function automatic logic [31:0] random_coord();
      begin
         case ($urandom_range(4))
            0: random_coord = $urandom;
            1: random_coord = $urandom_range(32'h0020_0000) - 32'h0010_0000;
            2: random_coord = {$urandom_range(1) ? 1'b1 : 1'b0, 31'($urandom)} | 32'h7fff_0000;
            3: random_coord = 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            default: random_coord = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         endcase
      end
   endfunction

   // directed: reset values, field extremes, near/behind camera, saturation
   task automatic test_directed_points;
      begin
         send_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
         send_point(32'h0, 32'h0, 32'h0);
         send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
         send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
         send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
         send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
         send_point(32'hffff_ffff, 32'h0000_0001, 32'h0000_ffff);
         send_point(32'h0010_0000, 32'hfff0_0000, 32'h0000_8000);
         send_point(32'h0003_0000, 32'h0005_0000, 32'hfff0_0000);
         // extreme registers: camera at corners gives 33-bit differences
         write_camera(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hfff, 32'hfff);
         send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
         send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
         send_point(32'h0, 32'h0, 32'h8001_0000);
         write_camera(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
         send_point(32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff);
         send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
         // index beyond the register file and dropped upper bits
         wait_drained();
         write_register(REG_UNUSED, 32'hdead_beef);
         write_register(REG_SPARE, 32'h1234_5678);
         write_camera(32'h0, 32'h0, 32'h0, 32'h0100_0000, 32'hffff_f140, 32'hffff_f0f0);
         send_point(32'h0002_0000, 32'hfffe_0000, 32'h0004_0000);
         send_point(32'h0, 32'h0, 32'h0001_0000);
      end
   endtask

   task automatic test_random_points(input int count);
      begin
         for (int i = 0; i < count; i++)
            send_point(random_coord(), random_coord(), random_coord());
      end
   endtask

   task automatic test_random_settings;
      begin
         for (int phase = 0; phase < 6; phase++) begin
            write_camera(random_coord(), random_coord(), random_coord(),
                         (phase % 2) ? $urandom : $urandom_range(32'h0400_0000),
                         $urandom, $urandom);
            test_random_points(110);
         end
      end
   endtask

   // back to back with no idling on either side
   task automatic test_full_rate;
      begin
         wait_drained();
         src_busy_idle = 1'b0;
         sink_busy_idle = 1'b0;
         write_camera(32'h0, 32'h0, 32'hfff0_0000, 32'h0140_0000, 32'd320, 32'd240);
         test_random_points(120);
         src_busy_idle = 1'b1;
         sink_busy_idle = 1'b1;
      end
   endtask

   // receiver holds off while sender keeps offering, filling the pipeline
   task automatic test_back_pressure;
      begin
         src_busy_idle = 1'b0;
         hold_cycles = 150;
         test_random_points(80);
         src_busy_idle = 1'b1;
      end
   endtask

   // receiver side: random stalls plus the forced hold
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (!reset) begin
         rsp_ready <= sink_busy_idle ? ($urandom_range(99) >= 34) : 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (screen_queue.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_data.screen_x, 32'h0);
         end else begin
            rsp_type want;
            want = screen_queue.pop_front();
            if (rsp_data.screen_x !== want.screen_x)
               report_mismatch("screen_x", rsp_data.screen_x, want.screen_x);
            if (rsp_data.screen_y !== want.screen_y)
               report_mismatch("screen_y", rsp_data.screen_y, want.screen_y);
         end
         checked_count++;
      end
   end

   initial begin
      #50_000_000;
      $display("Timeout with %0d transactions outstanding", screen_queue.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      cam_x_q = 0;
      cam_y_q = 0;
      cam_z_q = 0;
      focal_q = FOCAL_RESET;
      half_w_q = HALF_W_RESET;
      half_h_q = HALF_H_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_points();
      test_random_settings();
      test_full_rate();
      test_back_pressure();
      wait_drained();
      $display("Covered %0d points over directed extremes, random camera settings,",
               sent_count);
      $display("full-rate streaming and a long receiver hold; %0d results checked",
               checked_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
